[rtl/ksws_pkg.sv]
package ksws_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned WIN_W   = 5;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [WIN_W-1:0]          win_t;

  // heap sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,    // waiting for an input beat, root read in flight
    ST_ROOT,    // root data back: pass, bypass or swap with the minimum
    ST_UP_RD,   // sift-up: read parent of the hole
    ST_UP_CMP,  // sift-up: compare with parent, move it down or settle
    ST_DN_RD,   // sift-down: read both children of the hole
    ST_DN_CMP,  // sift-down: move the smaller child up or settle
    ST_FL_RD,   // flush: read root and tail entry
    ST_FL_POP   // flush: emit root, tail entry goes to the root
  } ksws_state_t;

endpackage

[rtl/ksws_heap_mem.sv]
module ksws_heap_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  ksws_pkg::value_t  wr_data,
  input  logic [AW-1:0]     rd_a_addr,
  input  logic [AW-1:0]     rd_b_addr,
  output ksws_pkg::value_t  rd_a_data,
  output ksws_pkg::value_t  rd_b_data
);

  ksws_pkg::value_t mem [DEPTH];
  ksws_pkg::value_t rd_a_r;
  ksws_pkg::value_t rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[rd_a_addr];
    rd_b_r <= mem[rd_b_addr];
  end

  assign rd_a_data = rd_a_r;
  assign rd_b_data = rd_b_r;

endmodule

[rtl/ksws_ctrl.sv]
module ksws_ctrl #(
  parameter int unsigned MAX_WINDOW = 16,
  parameter int unsigned AW         = 4,
  parameter int unsigned CNTW       = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  ksws_pkg::win_t    cfg_window_size,
  // input beats
  input  logic              in_valid,
  output logic              in_stall,
  input  ksws_pkg::value_t  in_value,
  input  logic              in_is_last,
  // result beats
  output logic              out_valid,
  input  logic              out_stall,
  output ksws_pkg::value_t  out_sorted_value,
  output logic              out_is_last_res,
  // heap memory
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output ksws_pkg::value_t  wr_data,
  output logic [AW-1:0]     rd_a_addr,
  output logic [AW-1:0]     rd_b_addr,
  input  ksws_pkg::value_t  rd_a_data,
  input  ksws_pkg::value_t  rd_b_data
);

  localparam int unsigned CHW = CNTW + 1;
  localparam int unsigned KW  = (CNTW > ksws_pkg::WIN_W) ? CNTW : ksws_pkg::WIN_W;

  ksws_pkg::ksws_state_t state_r, state_nxt;
  ksws_pkg::win_t        window_r;
  logic [CNTW-1:0]       count_r, count_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  ksws_pkg::value_t      val_r, val_nxt;
  logic                  last_r, last_nxt;

  logic                  out_valid_r;
  ksws_pkg::value_t      out_value_r;
  logic                  out_last_r;

  logic                  emit_en;
  ksws_pkg::value_t      emit_val;
  logic                  emit_last;
  logic                  out_free;

  logic [KW-1:0]         k_eff;
  logic                  count_lt_k;
  logic [CHW-1:0]        left_full, right_full, cnt_ext;
  logic                  has_left, has_right;
  logic [AW-1:0]         left_idx, right_idx, parent_idx, tail_idx;
  logic                  pick_right;
  ksws_pkg::value_t      child_val;
  logic [AW-1:0]         child_idx;
  ksws_pkg::ksws_state_t done_state;

  // window saturates at the heap depth
  assign k_eff = (KW'(window_r) > KW'(MAX_WINDOW)) ? KW'(MAX_WINDOW) : KW'(window_r);
  assign count_lt_k = KW'(count_r) < k_eff;

  assign cnt_ext    = CHW'(count_r);
  assign left_full  = (CHW'(idx_r) << 1) + CHW'(1);
  assign right_full = left_full + CHW'(1);
  assign has_left   = left_full < cnt_ext;
  assign has_right  = right_full < cnt_ext;
  assign left_idx   = AW'(left_full);
  assign right_idx  = has_right ? AW'(right_full) : left_idx;
  assign parent_idx = (idx_r - AW'(1)) >> 1;
  assign tail_idx   = AW'(count_r - CNTW'(1));
  assign pick_right = has_right && (rd_b_data < rd_a_data);
  assign child_val  = pick_right ? rd_b_data : rd_a_data;
  assign child_idx  = pick_right ? right_idx : left_idx;
  assign done_state = last_r ? ksws_pkg::ST_FL_RD : ksws_pkg::ST_IDLE;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ksws_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ksws_pkg::ST_IDLE;
      window_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_valid && cfg_ready) begin
        window_r <= cfg_window_size;
      end
      if (emit_en) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    val_r  <= val_nxt;
    last_r <= last_nxt;
    if (emit_en) begin
      out_value_r <= emit_val;
      out_last_r  <= emit_last;
    end
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    val_nxt   = val_r;
    last_nxt  = last_r;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_data   = val_r;
    rd_a_addr = '0;
    rd_b_addr = '0;
    emit_en   = 1'b0;
    emit_val  = val_r;
    emit_last = 1'b0;

    case (state_r)
      ksws_pkg::ST_IDLE: begin
        // root is read every idle cycle so it is ready in ST_ROOT
        if (in_valid) begin
          val_nxt  = in_value;
          last_nxt = in_is_last;
          if (count_lt_k) begin
            idx_nxt   = AW'(count_r);
            count_nxt = count_r + CNTW'(1);
            state_nxt = ksws_pkg::ST_UP_RD;
          end else begin
            state_nxt = ksws_pkg::ST_ROOT;
          end
        end
      end

      ksws_pkg::ST_ROOT: begin
        if (out_free) begin
          emit_en = 1'b1;
          if (count_r == '0) begin
            emit_last = last_r;
            state_nxt = ksws_pkg::ST_IDLE;
          end else if (val_r < rd_a_data) begin
            state_nxt = done_state;
          end else begin
            // emit the minimum, new value replaces the root
            emit_val  = rd_a_data;
            idx_nxt   = '0;
            state_nxt = ksws_pkg::ST_DN_RD;
          end
        end
      end

      ksws_pkg::ST_UP_RD: begin
        rd_a_addr = parent_idx;
        if (idx_r == '0) begin
          wr_en     = 1'b1;
          state_nxt = done_state;
        end else begin
          state_nxt = ksws_pkg::ST_UP_CMP;
        end
      end

      ksws_pkg::ST_UP_CMP: begin
        rd_a_addr = parent_idx;
        wr_en     = 1'b1;
        if (val_r < rd_a_data) begin
          wr_data   = rd_a_data;
          idx_nxt   = parent_idx;
          state_nxt = ksws_pkg::ST_UP_RD;
        end else begin
          state_nxt = done_state;
        end
      end

      ksws_pkg::ST_DN_RD: begin
        rd_a_addr = left_idx;
        rd_b_addr = right_idx;
        if (!has_left) begin
          wr_en     = 1'b1;
          state_nxt = done_state;
        end else begin
          state_nxt = ksws_pkg::ST_DN_CMP;
        end
      end

      ksws_pkg::ST_DN_CMP: begin
        rd_a_addr = left_idx;
        rd_b_addr = right_idx;
        wr_en     = 1'b1;
        if (child_val < val_r) begin
          wr_data   = child_val;
          idx_nxt   = child_idx;
          state_nxt = ksws_pkg::ST_DN_RD;
        end else begin
          state_nxt = done_state;
        end
      end

      ksws_pkg::ST_FL_RD: begin
        rd_b_addr = tail_idx;
        if (count_r == '0) begin
          state_nxt = ksws_pkg::ST_IDLE;
        end else begin
          state_nxt = ksws_pkg::ST_FL_POP;
        end
      end

      ksws_pkg::ST_FL_POP: begin
        rd_b_addr = tail_idx;
        if (out_free) begin
          emit_en   = 1'b1;
          emit_val  = rd_a_data;
          emit_last = (count_r == CNTW'(1));
          count_nxt = count_r - CNTW'(1);
          if (count_r == CNTW'(1)) begin
            state_nxt = ksws_pkg::ST_IDLE;
          end else begin
            val_nxt   = rd_b_data;
            idx_nxt   = '0;
            state_nxt = ksws_pkg::ST_DN_RD;
          end
        end
      end

      default: begin
        state_nxt = ksws_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_is_last_res  = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CNTW'(count_r) <= CNTW'(MAX_WINDOW))
    else $error("heap count beyond depth");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit_en |-> !(out_valid_r && out_stall))
    else $error("result overwrites a stalled beat");

  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ksws_pkg::ST_ROOT || state_r == ksws_pkg::ST_UP_RD))
    else $error("accepted beat not taken up");

  a_pop_emits: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && count_r < $past(count_r)) |-> $past(emit_en))
    else $error("value dropped from heap without a result");

  a_last_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_en && emit_last) |=> (count_r == '0))
    else $error("final result with values still held");

endmodule

[rtl/k_sorted_window_sorter_unit.sv]
// Sorter for nearly sorted streams: every value lies at most window_size
// places from its sorted position. Values are held in a min-heap kept in a
// small two-read, one-write synchronous memory.
// Input beat: in_value / in_is_last, taken when in_valid is high and
// in_stall low. Result beat: out_sorted_value / out_is_last_res, taken when
// out_valid is high and out_stall low. cfg_window_size is written through
// cfg_valid / cfg_ready (always ready), only while the block is idle: a
// rule for the user that the block does not enforce. While the heap fills
// no result is given; once full, each beat yields one result (the new
// value or the heap minimum). The beat flagged last flushes the heap in
// ascending order and marks the final result. An insert sifts the new
// value up from the tail; a swap with the minimum and each flushed value
// sift down from the root; the sift loop does one memory read and one
// compare per heap level. Reset empties the heap and clears window_size
// to 0 (pass-through); the heap memory itself is not cleared. A stalled
// result holds; the block still takes the next input beat and waits only
// when it has a further result to place.
module k_sorted_window_sorter_unit #(
  parameter int unsigned MAX_WINDOW = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  ksws_pkg::win_t    cfg_window_size,
  input  logic              in_valid,
  output logic              in_stall,
  input  ksws_pkg::value_t  in_value,
  input  logic              in_is_last,
  output logic              out_valid,
  input  logic              out_stall,
  output ksws_pkg::value_t  out_sorted_value,
  output logic              out_is_last_res
);

  localparam int unsigned AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CNTW = $clog2(MAX_WINDOW + 1);

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  ksws_pkg::value_t wr_data;
  logic [AW-1:0]    rd_a_addr;
  logic [AW-1:0]    rd_b_addr;
  ksws_pkg::value_t rd_a_data;
  ksws_pkg::value_t rd_b_data;

  ksws_ctrl #(
    .MAX_WINDOW (MAX_WINDOW),
    .AW         (AW),
    .CNTW       (CNTW)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_window_size  (cfg_window_size),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .in_is_last       (in_is_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sorted_value (out_sorted_value),
    .out_is_last_res  (out_is_last_res),
    .wr_en            (wr_en),
    .wr_addr          (wr_addr),
    .wr_data          (wr_data),
    .rd_a_addr        (rd_a_addr),
    .rd_b_addr        (rd_b_addr),
    .rd_a_data        (rd_a_data),
    .rd_b_data        (rd_b_data)
  );

  ksws_heap_mem #(
    .DEPTH (MAX_WINDOW),
    .AW    (AW)
  ) u_heap_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data)
  );

endmodule
